FILE: hdl/iwf3_pkg.sv
// shared types and constants for the 3x3 window filter
`timescale 1ns / 1ps
package iwf3_pkg;

  localparam int PIX_W      = 8;
  localparam int ROW_W      = 12;
  localparam int MODE_W     = 2;
  localparam int ROWS_W     = 13;
  localparam int COLS_W     = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  localparam logic [MODE_W-1:0] MODE_MEAN   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_MEDIAN = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SOBEL  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS = 2'd2;

  localparam logic [MODE_W-1:0] MODE_RST = 2'd0;
  localparam logic [ROWS_W-1:0] ROWS_RST = 13'd3;
  localparam logic [COLS_W-1:0] COLS_RST = 11'd3;
  localparam logic [ROWS_W-1:0] ROWS_MIN = 13'd3;
  localparam logic [ROWS_W-1:0] ROWS_MAX = 13'd4096;
  localparam logic [12:0]       COLS_MIN = 13'd3;

  // sobel taps, window order
  localparam logic signed [2:0] GX_K [9] = '{-3'sd1, 3'sd0, 3'sd1, -3'sd2, 3'sd0, 3'sd2,
                                             -3'sd1, 3'sd0, 3'sd1};
  localparam logic signed [2:0] GY_K [9] = '{-3'sd1, -3'sd2, -3'sd1, 3'sd0, 3'sd0, 3'sd0,
                                             3'sd1, 3'sd2, 3'sd1};

  // floor(s / 9) == (s * 7282) >> 16 for any nine-pixel sum
  localparam logic [12:0] MEAN_RECIP = 13'd7282;
  localparam int          MEAN_SHIFT = 16;

  localparam logic [3:0] MED_RANK = 4'd4;
  localparam logic [3:0] MED_LAST = 4'd8;
  localparam logic [3:0] ROOT_TOP = 4'd8;

  typedef logic [8:0][PIX_W-1:0] win_t;

  typedef struct packed {
    logic emit_prev;
    logic emit_last_col;
    logic emit_self;
    logic interior;
    logic frame_end;
  } flags_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_PREP,
    BK_DIV,
    BK_MED,
    BK_SQ,
    BK_SQRT,
    BK_EMIT
  } bk_state_t;

endpackage

FILE: hdl/image_window_filter_3x3_unit.sv
// top level of the 3x3 mean / median / sobel window filter
//
//  channel   direction  handshake            payload
//  in_       input      push / full          in_pixel_in
//  out_      output     empty / pop          out_pixel_out, out_row, out_col,
//                                            out_run_last, out_frame_end
//  cfg_      input      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// the front takes one pixel per clock while the word queue has room
// the back sequencer sets the sustained rate: per queued pixel it runs prep,
// then mean divide, median search (one candidate a cycle) or sobel square and
// root (9-bit root, one bit a cycle), then emit; border and copy skip to emit
// synchronous active-low reset clears counters, window, queue and sequencer;
// line stores are not cleared and need no sweep
// a stalled result holds the back; the front stalls only once the queue fills
`timescale 1ns / 1ps
module image_window_filter_3x3_unit #(
  parameter int MAX_COLS    = 1024,
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   push,
  output logic                                   full,
  input  logic [iwf3_pkg::PIX_W-1:0]             in_pixel_in,
  output logic                                   empty,
  input  logic                                   pop,
  output logic [iwf3_pkg::PIX_W-1:0]             out_pixel_out,
  output logic [iwf3_pkg::ROW_W-1:0]             out_row,
  output logic [$clog2(MAX_COLS)-1:0]            out_col,
  output logic                                   out_run_last,
  output logic                                   out_frame_end,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [iwf3_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [iwf3_pkg::CFG_DATA_W-1:0]        cfg_data
);

  localparam int COL_W = $clog2(MAX_COLS);
  localparam int DW = $bits(iwf3_pkg::flags_t) + iwf3_pkg::ROW_W + COL_W
                      + $bits(iwf3_pkg::win_t);

  logic [iwf3_pkg::MODE_W-1:0] mode_r;
  logic [iwf3_pkg::ROWS_W-1:0] rows_r;
  logic [iwf3_pkg::COLS_W-1:0] cols_r;

  logic                        q_push, q_full, q_pop, q_empty;
  logic [DW-1:0]               q_din, q_dout;
  iwf3_pkg::win_t              f_win, b_win;
  iwf3_pkg::flags_t            f_flags, b_flags;
  logic [iwf3_pkg::ROW_W-1:0]  f_row, b_row;
  logic [COL_W-1:0]            f_col, b_col;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= iwf3_pkg::MODE_RST;
      rows_r <= iwf3_pkg::ROWS_RST;
      cols_r <= iwf3_pkg::COLS_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        iwf3_pkg::CFG_MODE: mode_r <= cfg_data[iwf3_pkg::MODE_W-1:0];
        iwf3_pkg::CFG_ROWS: rows_r <= cfg_data;
        iwf3_pkg::CFG_COLS: cols_r <= cfg_data[iwf3_pkg::COLS_W-1:0];
        default: ;
      endcase
    end
  end

  iwf3_front #(
    .MAX_COLS (MAX_COLS),
    .COL_W    (COL_W)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .pixel    (in_pixel_in),
    .full     (full),
    .num_rows (rows_r),
    .num_cols (cols_r),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_win    (f_win),
    .q_flags  (f_flags),
    .q_row    (f_row),
    .q_col    (f_col)
  );

  assign q_din = {f_flags, f_row, f_col, f_win};
  assign {b_flags, b_row, b_col, b_win} = q_dout;

  iwf3_queue #(
    .DW    (DW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (q_push),
    .din   (q_din),
    .full  (q_full),
    .rd    (q_pop),
    .dout  (q_dout),
    .empty (q_empty)
  );

  iwf3_back #(
    .COL_W (COL_W)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .mode      (mode_r),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .e_win     (b_win),
    .e_flags   (b_flags),
    .e_row     (b_row),
    .e_col     (b_col),
    .empty     (empty),
    .pop       (pop),
    .pixel     (out_pixel_out),
    .row       (out_row),
    .col       (out_col),
    .run_last  (out_run_last),
    .frame_end (out_frame_end)
  );

endmodule

FILE: hdl/iwf3_queue.sv
// small word queue between the front and the back
`timescale 1ns / 1ps
module iwf3_queue #(
  parameter int DW    = 8,
  parameter int DEPTH = 2
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr,
  input  logic [DW-1:0] din,
  output logic          full,
  input  logic          rd,
  output logic [DW-1:0] dout,
  output logic          empty
);

  localparam int PW = $clog2(DEPTH);
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [DW-1:0]   mem_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CNTW-1:0] count_r;

  assign full  = (count_r == CNTW'(DEPTH));
  assign empty = (count_r == '0);
  assign dout  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (wr) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (wr) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (rd) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (wr && !rd) begin
        count_r <= count_r + 1'b1;
      end else if (rd && !wr) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    wr |-> (count_r < CNTW'(DEPTH) || rd))
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    rd |-> (count_r != '0))
    else $error("queue read while empty");
  a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
    (wr && !rd) |=> (count_r == $past(count_r) + 1'b1))
    else $error("queue count lost a word");
`endif

endmodule

FILE: hdl/iwf3_front.sv
// front end: position counters, line stores, window and result classification
`timescale 1ns / 1ps
module iwf3_front #(
  parameter int MAX_COLS = 1024,
  parameter int COL_W    = 10
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  input  logic [iwf3_pkg::PIX_W-1:0]    pixel,
  output logic                          full,
  input  logic [iwf3_pkg::ROWS_W-1:0]   num_rows,
  input  logic [iwf3_pkg::COLS_W-1:0]   num_cols,
  input  logic                          q_full,
  output logic                          q_push,
  output iwf3_pkg::win_t                q_win,
  output iwf3_pkg::flags_t              q_flags,
  output logic [iwf3_pkg::ROW_W-1:0]    q_row,
  output logic [COL_W-1:0]              q_col
);

  localparam int RW = iwf3_pkg::ROW_W;

  logic [iwf3_pkg::PIX_W-1:0] upper_mem [MAX_COLS];
  logic [iwf3_pkg::PIX_W-1:0] lower_mem [MAX_COLS];

  logic [RW-1:0]              row_r;
  logic [COL_W-1:0]           col_r;
  logic                       va_r;
  logic [iwf3_pkg::PIX_W-1:0] px_a_r, top_a_r, mid_a_r;
  logic [RW-1:0]              r_a_r;
  logic [COL_W-1:0]           c_a_r;
  iwf3_pkg::flags_t           fl_a_r;
  iwf3_pkg::win_t             win_r;

  logic [12:0]                cols13;
  logic [COL_W:0]             cols_eff;
  logic [iwf3_pkg::ROWS_W-1:0] rows_eff;
  logic                       accept, a_go, a_none;
  logic [COL_W-1:0]           c0, c1;
  logic [RW-1:0]              r0, r1;
  logic [RW:0]                r0t, r1t;
  logic [COL_W:0]             c1t;
  logic                       c_last;
  iwf3_pkg::flags_t           fl_nxt;
  iwf3_pkg::win_t             win_nxt;

  always_comb begin
    cols13 = {2'b00, num_cols};
    if (cols13 < iwf3_pkg::COLS_MIN) begin
      cols13 = iwf3_pkg::COLS_MIN;
    end else if (cols13 > 13'(MAX_COLS)) begin
      cols13 = 13'(MAX_COLS);
    end
    cols_eff = cols13[COL_W:0];
    rows_eff = num_rows;
    if (rows_eff < iwf3_pkg::ROWS_MIN) begin
      rows_eff = iwf3_pkg::ROWS_MIN;
    end else if (rows_eff > iwf3_pkg::ROWS_MAX) begin
      rows_eff = iwf3_pkg::ROWS_MAX;
    end
  end

  // position of the arriving pixel, wrapping if the geometry shrank
  always_comb begin
    if ({1'b0, col_r} >= cols_eff) begin
      c0  = '0;
      r0t = {1'b0, row_r} + 1'b1;
    end else begin
      c0  = col_r;
      r0t = {1'b0, row_r};
    end
    r0 = (r0t >= rows_eff) ? '0 : r0t[RW-1:0];
    c1t = {1'b0, c0} + 1'b1;
    if (c1t >= cols_eff) begin
      c1  = '0;
      r1t = {1'b0, r0} + 1'b1;
      r1  = (r1t >= rows_eff) ? '0 : r1t[RW-1:0];
    end else begin
      c1  = c1t[COL_W-1:0];
      r1t = {1'b0, r0};
      r1  = r0;
    end
    c_last = ({1'b0, c0} == cols_eff - 1'b1);
    fl_nxt.emit_prev     = (r0 != '0) && (c0 != '0);
    fl_nxt.emit_last_col = (r0 != '0) && c_last;
    fl_nxt.emit_self     = (r0 != '0) && ({1'b0, r0} == rows_eff - 1'b1);
    fl_nxt.interior      = (r0 >= RW'(2)) && (c0 >= COL_W'(2));
    fl_nxt.frame_end     = c_last;
  end

  assign a_none = !(fl_a_r.emit_prev || fl_a_r.emit_last_col || fl_a_r.emit_self);
  assign a_go   = va_r && (!q_full || a_none);
  assign full   = va_r && !a_go;
  assign accept = push && !full;

  always_comb begin
    win_nxt    = win_r;
    win_nxt[0] = win_r[1];
    win_nxt[1] = win_r[2];
    win_nxt[2] = top_a_r;
    win_nxt[3] = win_r[4];
    win_nxt[4] = win_r[5];
    win_nxt[5] = mid_a_r;
    win_nxt[6] = win_r[7];
    win_nxt[7] = win_r[8];
    win_nxt[8] = px_a_r;
  end

  assign q_push  = a_go && !a_none;
  assign q_win   = win_nxt;
  assign q_flags = fl_a_r;
  assign q_row   = r_a_r;
  assign q_col   = c_a_r;

  // line stores: read old row values, then age them one row
  always_ff @(posedge clk) begin
    if (accept) begin
      lower_mem[c0] <= pixel;
      mid_a_r       <= lower_mem[c0];
      top_a_r       <= upper_mem[c0];
    end
    if (a_go) begin
      upper_mem[c_a_r] <= mid_a_r;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      px_a_r <= pixel;
      r_a_r  <= r0;
      c_a_r  <= c0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r  <= '0;
      col_r  <= '0;
      va_r   <= 1'b0;
      fl_a_r <= '0;
      win_r  <= '0;
    end else begin
      if (accept) begin
        row_r  <= r1;
        col_r  <= c1;
        fl_a_r <= fl_nxt;
        va_r   <= 1'b1;
      end else if (a_go) begin
        va_r <= 1'b0;
      end
      if (a_go) begin
        win_r <= win_nxt;
      end
    end
  end

endmodule

FILE: hdl/iwf3_back.sv
// back end: filter arithmetic sequencer and result delivery
`timescale 1ns / 1ps
module iwf3_back #(
  parameter int COL_W = 10
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [iwf3_pkg::MODE_W-1:0]   mode,
  input  logic                          q_empty,
  output logic                          q_pop,
  input  iwf3_pkg::win_t                e_win,
  input  iwf3_pkg::flags_t              e_flags,
  input  logic [iwf3_pkg::ROW_W-1:0]    e_row,
  input  logic [COL_W-1:0]              e_col,
  output logic                          empty,
  input  logic                          pop,
  output logic [iwf3_pkg::PIX_W-1:0]    pixel,
  output logic [iwf3_pkg::ROW_W-1:0]    row,
  output logic [COL_W-1:0]              col,
  output logic                          run_last,
  output logic                          frame_end
);

  localparam int RW = iwf3_pkg::ROW_W;
  localparam int PW = iwf3_pkg::PIX_W;

  iwf3_pkg::bk_state_t state_r, state_nxt;
  logic [2:0]          pend_r, pend_nxt;

  iwf3_pkg::win_t      win_r, win_nxt;
  iwf3_pkg::flags_t    fl_r, fl_nxt;
  logic [RW-1:0]       row_r, row_nxt;
  logic [COL_W-1:0]    col_r, col_nxt;
  logic [11:0]         sum_r, sum_nxt;
  logic signed [8:0]   gx_r, gx_nxt, gy_r, gy_nxt;
  logic [PW-1:0]       val_r, val_nxt;
  logic [3:0]          k_r, k_nxt;
  logic [16:0]         sq_r, sq_nxt;
  logic [8:0]          root_r, root_nxt;
  logic [3:0]          bit_r, bit_nxt;

  logic signed [10:0]  acc_x, acc_y, qx, qy;
  logic [24:0]         mprod;
  logic [PW-1:0]       cand;
  logic [3:0]          lt_cnt, le_cnt;
  logic signed [17:0]  px2, py2;
  logic [8:0]          trial;
  logic [17:0]         tsq;
  logic [2:0]          sel;

  always_comb begin
    sum_nxt = '0;
    acc_x   = '0;
    acc_y   = '0;
    for (int i = 0; i < 9; i++) begin
      sum_nxt = sum_nxt + 12'(win_r[i]);
      acc_x = acc_x + $signed({3'b000, win_r[i]}) * 11'(iwf3_pkg::GX_K[i]);
      acc_y = acc_y + $signed({3'b000, win_r[i]}) * 11'(iwf3_pkg::GY_K[i]);
    end
    // divide by four, rounding toward zero
    qx = acc_x[10] ? ((acc_x + 11'sd3) >>> 2) : (acc_x >>> 2);
    qy = acc_y[10] ? ((acc_y + 11'sd3) >>> 2) : (acc_y >>> 2);
  end

  assign mprod = sum_r * iwf3_pkg::MEAN_RECIP;

  // rank of the current median candidate
  always_comb begin
    cand   = win_r[k_r];
    lt_cnt = '0;
    le_cnt = '0;
    for (int j = 0; j < 9; j++) begin
      lt_cnt = lt_cnt + 4'(win_r[j] < cand);
      le_cnt = le_cnt + 4'(win_r[j] <= cand);
    end
  end

  assign px2   = gx_r * gx_r;
  assign py2   = gy_r * gy_r;
  assign trial = root_r | (9'd1 << bit_r);
  assign tsq   = trial * trial;

  assign sel = pend_r[0] ? 3'b001 : (pend_r[1] ? 3'b010 : 3'b100);

  always_comb begin
    state_nxt = state_r;
    pend_nxt  = pend_r;
    win_nxt   = win_r;
    fl_nxt    = fl_r;
    row_nxt   = row_r;
    col_nxt   = col_r;
    gx_nxt    = gx_r;
    gy_nxt    = gy_r;
    val_nxt   = val_r;
    k_nxt     = k_r;
    sq_nxt    = sq_r;
    root_nxt  = root_r;
    bit_nxt   = bit_r;
    q_pop     = 1'b0;
    case (state_r)
      iwf3_pkg::BK_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          win_nxt   = e_win;
          fl_nxt    = e_flags;
          row_nxt   = e_row;
          col_nxt   = e_col;
          pend_nxt  = {e_flags.emit_self, e_flags.emit_last_col, e_flags.emit_prev};
          state_nxt = iwf3_pkg::BK_PREP;
        end
      end
      iwf3_pkg::BK_PREP: begin
        gx_nxt  = qx[8:0];
        gy_nxt  = qy[8:0];
        val_nxt = win_r[4];
        k_nxt   = '0;
        if (!fl_r.interior) begin
          state_nxt = iwf3_pkg::BK_EMIT;
        end else begin
          case (mode)
            iwf3_pkg::MODE_MEAN:   state_nxt = iwf3_pkg::BK_DIV;
            iwf3_pkg::MODE_MEDIAN: state_nxt = iwf3_pkg::BK_MED;
            iwf3_pkg::MODE_SOBEL:  state_nxt = iwf3_pkg::BK_SQ;
            default:               state_nxt = iwf3_pkg::BK_EMIT;
          endcase
        end
      end
      iwf3_pkg::BK_DIV: begin
        val_nxt   = mprod[iwf3_pkg::MEAN_SHIFT+PW-1:iwf3_pkg::MEAN_SHIFT];
        state_nxt = iwf3_pkg::BK_EMIT;
      end
      iwf3_pkg::BK_MED: begin
        if ((lt_cnt <= iwf3_pkg::MED_RANK && le_cnt > iwf3_pkg::MED_RANK)
            || k_r == iwf3_pkg::MED_LAST) begin
          val_nxt   = cand;
          state_nxt = iwf3_pkg::BK_EMIT;
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
      iwf3_pkg::BK_SQ: begin
        sq_nxt    = px2[16:0] + py2[16:0];
        root_nxt  = '0;
        bit_nxt   = iwf3_pkg::ROOT_TOP;
        state_nxt = iwf3_pkg::BK_SQRT;
      end
      iwf3_pkg::BK_SQRT: begin
        // one root bit per cycle, msb first
        if (tsq <= {1'b0, sq_r}) begin
          root_nxt = trial;
        end
        if (bit_r == '0) begin
          val_nxt   = root_nxt[8] ? {PW{1'b1}} : root_nxt[PW-1:0];
          state_nxt = iwf3_pkg::BK_EMIT;
        end else begin
          bit_nxt = bit_r - 1'b1;
        end
      end
      iwf3_pkg::BK_EMIT: begin
        if (pop) begin
          pend_nxt = pend_r & ~sel;
          if ((pend_r & ~sel) == 3'b000) begin
            state_nxt = iwf3_pkg::BK_IDLE;
          end
        end
      end
      default: state_nxt = iwf3_pkg::BK_IDLE;
    endcase
  end

  assign empty    = (state_r != iwf3_pkg::BK_EMIT);
  assign run_last = ((pend_r & ~sel) == 3'b000);

  always_comb begin
    case (sel)
      3'b001: begin
        pixel     = val_r;
        row       = row_r - 1'b1;
        col       = col_r - 1'b1;
        frame_end = 1'b0;
      end
      3'b010: begin
        pixel     = win_r[5];
        row       = row_r - 1'b1;
        col       = col_r;
        frame_end = 1'b0;
      end
      default: begin
        pixel     = win_r[8];
        row       = row_r;
        col       = col_r;
        frame_end = fl_r.frame_end;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= iwf3_pkg::BK_IDLE;
      pend_r  <= '0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    win_r  <= win_nxt;
    fl_r   <= fl_nxt;
    row_r  <= row_nxt;
    col_r  <= col_nxt;
    sum_r  <= sum_nxt;
    gx_r   <= gx_nxt;
    gy_r   <= gy_nxt;
    val_r  <= val_nxt;
    k_r    <= k_nxt;
    sq_r   <= sq_nxt;
    root_r <= root_nxt;
    bit_r  <= bit_nxt;
  end

endmodule
